// ===== src/jsu_pkg.sv =====
package jsu_pkg;

    // Decoder phase codes
    localparam logic [2:0] PH_WAIT   = 3'd0;
    localparam logic [2:0] PH_BODY   = 3'd1;
    localparam logic [2:0] PH_ESC    = 3'd2;
    localparam logic [2:0] PH_HEX1   = 3'd3;
    localparam logic [2:0] PH_BSLASH = 3'd4;
    localparam logic [2:0] PH_LOWU   = 3'd5;
    localparam logic [2:0] PH_HEX2   = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NO_QUOTE     = 4'd0;
    localparam logic [3:0] ERR_CONTROL      = 4'd1;
    localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd2;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
    localparam logic [3:0] ERR_SHORT_HEX    = 4'd4;
    localparam logic [3:0] ERR_UNPAIRED     = 4'd5;
    localparam logic [3:0] ERR_BAD_LOW      = 4'd6;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd7;
    localparam logic [3:0] ERR_TRUNCATED    = 4'd8;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6e;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Surrogate ranges
    localparam logic [15:0] HIGH_SUR_LO = 16'hd800;
    localparam logic [15:0] HIGH_SUR_HI = 16'hdbff;
    localparam logic [15:0] LOW_SUR_LO  = 16'hdc00;
    localparam logic [15:0] LOW_SUR_HI  = 16'hdfff;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // Results one input byte can cause
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] err;
    } jsu_result_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  digits;
        logic [15:0] accum;
        logic [9:0]  high_half;
    } jsu_state_t;

    function automatic jsu_result_t make_err(input logic [3:0] code);
        jsu_result_t r;
        r.kind = KIND_ERR;
        r.data = 8'h00;
        r.err  = code;
        return r;
    endfunction

    function automatic jsu_result_t make_byte(input logic [7:0] b);
        jsu_result_t r;
        r.kind = KIND_BYTE;
        r.data = b;
        r.err  = 4'd0;
        return r;
    endfunction

endpackage

// ===== src/jsu_decode.sv =====
module jsu_decode
    import jsu_pkg::*;
(
    input  jsu_state_t        cur,
    input  logic [7:0]        in_byte,
    input  logic              input_end,
    output jsu_state_t        nxt,
    output jsu_result_t       res [MAX_RESULTS],
    output logic [CNT_W-1:0]  res_cnt
);

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] accum_new;
    logic        quad_done;
    logic [20:0] cp;
    jsu_result_t utf [MAX_RESULTS];
    logic [CNT_W-1:0] utf_cnt;

    // Hex digit value
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_val = 4'(in_byte - 8'h30);
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
            hex_val = 4'(in_byte - 8'h57);
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
            hex_val = 4'(in_byte - 8'h37);
        else
            hex_ok = 1'b0;
    end

    assign accum_new = {cur.accum[11:0], hex_val};
    assign quad_done = (cur.digits == 2'd3);

    // Code point: plain quad, or joined surrogate pair
    assign cp = (cur.phase == PH_HEX2)
              ? SUPP_BASE + {1'b0, cur.high_half, accum_new[9:0]}
              : {5'd0, accum_new};

    // UTF-8 encoding of the code point
    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
            utf[i] = make_byte(8'h00);
        if (cp <= 21'h7f) begin
            utf[0]  = make_byte(cp[7:0]);
            utf_cnt = CNT_W'(1);
        end else if (cp <= 21'h7ff) begin
            utf[0]  = make_byte({3'b110, cp[10:6]});
            utf[1]  = make_byte({2'b10, cp[5:0]});
            utf_cnt = CNT_W'(2);
        end else if (cp <= 21'hffff) begin
            utf[0]  = make_byte({4'b1110, cp[15:12]});
            utf[1]  = make_byte({2'b10, cp[11:6]});
            utf[2]  = make_byte({2'b10, cp[5:0]});
            utf_cnt = CNT_W'(3);
        end else begin
            utf[0]  = make_byte({5'b11110, cp[20:18]});
            utf[1]  = make_byte({2'b10, cp[17:12]});
            utf[2]  = make_byte({2'b10, cp[11:6]});
            utf[3]  = make_byte({2'b10, cp[5:0]});
            utf_cnt = CNT_W'(4);
        end
    end

    // Step the decoder by one byte
    always_comb
    begin
        nxt     = cur;
        res_cnt = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
            res[i] = make_byte(8'h00);

        unique case (cur.phase)
            PH_BODY:
            begin
                res_cnt = CNT_W'(1);
                if (input_end) begin
                    res[0]    = make_err(ERR_UNTERMINATED);
                    nxt.phase = PH_WAIT;
                end else if (in_byte == CH_QUOTE) begin
                    res[0].kind = KIND_CLOSE;
                    nxt.phase   = PH_WAIT;
                end else if (in_byte < CH_SPACE) begin
                    res[0]    = make_err(ERR_CONTROL);
                    nxt.phase = PH_WAIT;
                end else if (in_byte == CH_BSLASH) begin
                    res_cnt   = '0;
                    nxt.phase = PH_ESC;
                end else begin
                    res[0] = make_byte(in_byte);
                end
            end
            PH_ESC:
            begin
                res_cnt = CNT_W'(1);
                if (input_end) begin
                    res[0]    = make_err(ERR_TRUNCATED);
                    nxt.phase = PH_WAIT;
                end else begin
                    nxt.phase = PH_BODY;
                    unique case (in_byte)
                        CH_QUOTE:  res[0] = make_byte(CH_QUOTE);
                        CH_BSLASH: res[0] = make_byte(CH_BSLASH);
                        CH_SLASH:  res[0] = make_byte(CH_SLASH);
                        CH_LC_B:   res[0] = make_byte(CH_BS);
                        CH_LC_F:   res[0] = make_byte(CH_FF);
                        CH_LC_N:   res[0] = make_byte(CH_LF);
                        CH_LC_R:   res[0] = make_byte(CH_CR);
                        CH_LC_T:   res[0] = make_byte(CH_TAB);
                        CH_LC_U:
                        begin
                            res_cnt    = '0;
                            nxt.phase  = PH_HEX1;
                            nxt.digits = 2'd0;
                            nxt.accum  = 16'd0;
                        end
                        default:
                        begin
                            res[0]    = make_err(ERR_BAD_ESCAPE);
                            nxt.phase = PH_WAIT;
                        end
                    endcase
                end
            end
            PH_HEX1, PH_HEX2:
            begin
                if (input_end) begin
                    res_cnt   = CNT_W'(1);
                    res[0]    = make_err((cur.phase == PH_HEX1) ? ERR_SHORT_HEX
                                                                : ERR_UNPAIRED);
                    nxt.phase = PH_WAIT;
                end else if (!hex_ok) begin
                    res_cnt   = CNT_W'(1);
                    res[0]    = make_err(ERR_BAD_HEX);
                    nxt.phase = PH_WAIT;
                end else begin
                    nxt.accum = accum_new;
                    if (!quad_done) begin
                        nxt.digits = cur.digits + 2'd1;
                    end else begin
                        nxt.digits = 2'd0;
                        if (cur.phase == PH_HEX1 && accum_new >= HIGH_SUR_LO
                            && accum_new <= HIGH_SUR_HI) begin
                            // hold the high half until the low surrogate arrives
                            nxt.high_half = accum_new[9:0];
                            nxt.phase     = PH_BSLASH;
                        end else if (cur.phase == PH_HEX1 && accum_new >= LOW_SUR_LO
                                     && accum_new <= LOW_SUR_HI) begin
                            res_cnt   = CNT_W'(1);
                            res[0]    = make_err(ERR_UNPAIRED);
                            nxt.phase = PH_WAIT;
                        end else if (cur.phase == PH_HEX2 && (accum_new < LOW_SUR_LO
                                     || accum_new > LOW_SUR_HI)) begin
                            res_cnt   = CNT_W'(1);
                            res[0]    = make_err(ERR_BAD_LOW);
                            nxt.phase = PH_WAIT;
                        end else begin
                            res       = utf;
                            res_cnt   = utf_cnt;
                            nxt.phase = PH_BODY;
                        end
                    end
                end
            end
            PH_BSLASH:
            begin
                if (input_end || in_byte != CH_BSLASH) begin
                    res_cnt   = CNT_W'(1);
                    res[0]    = make_err(ERR_UNPAIRED);
                    nxt.phase = PH_WAIT;
                end else begin
                    nxt.phase = PH_LOWU;
                end
            end
            PH_LOWU:
            begin
                if (input_end || in_byte != CH_LC_U) begin
                    res_cnt   = CNT_W'(1);
                    res[0]    = make_err(ERR_UNPAIRED);
                    nxt.phase = PH_WAIT;
                end else begin
                    nxt.phase  = PH_HEX2;
                    nxt.digits = 2'd0;
                    nxt.accum  = 16'd0;
                end
            end
            default:
            begin
                nxt.phase = PH_WAIT;
                if (input_end) begin
                    res_cnt = CNT_W'(1);
                    res[0]  = make_err(ERR_TRUNCATED);
                end else if (in_byte == CH_QUOTE) begin
                    nxt.phase = PH_BODY;
                end else begin
                    res_cnt = CNT_W'(1);
                    res[0]  = make_err(ERR_NO_QUOTE);
                end
            end
        endcase
    end

endmodule

// ===== src/json_string_unescape_utf8.sv =====
// JSON string unescaper: feed a string token one raw byte per transaction,
// starting at the opening quote; tuser high marks end of input and carries no
// byte. Each result is a decoded UTF-8 byte, a "string closed" marker or an
// error code, and tlast flags the final result caused by one input byte. A
// byte is decoded in the cycle it is accepted and its results are loaded into
// a four-entry output buffer that drains one result per cycle while m_axis_tready
// is high, so input runs at one byte per cycle while the sink is ready, except
// behind a multi-byte UTF-8 \u escape, where input stalls while the buffer empties.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] input_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] error_code, zero above
    output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
    output logic        m_axis_tlast    // last_of_run
);

    jsu_state_t       state_reg;
    jsu_state_t       state_next;
    jsu_result_t      dec_res [MAX_RESULTS];
    logic [CNT_W-1:0] dec_cnt;
    jsu_result_t      buf_reg [MAX_RESULTS];
    logic [CNT_W-1:0] cnt_reg;
    logic             in_take;
    logic             out_take;

    jsu_decode u_decode (
        .cur       (state_reg),
        .in_byte   (s_axis_tdata),
        .input_end (s_axis_tuser),
        .nxt       (state_next),
        .res       (dec_res),
        .res_cnt   (dec_cnt)
    );

    // Accept when the buffer is empty or drains its last entry this cycle
    assign s_axis_tready = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && m_axis_tready);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_take      = m_axis_tvalid && m_axis_tready;

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = {4'd0, buf_reg[0].err, buf_reg[0].data};
    assign m_axis_tuser  = buf_reg[0].kind;
    assign m_axis_tlast  = (cnt_reg == CNT_W'(1));

    // Advance decoder state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (in_take) begin
            state_reg <= state_next;
        end
    end

    // Track result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else if (in_take) begin
            cnt_reg <= dec_cnt;
        end else if (out_take) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Load results, or shift the head out
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            buf_reg <= dec_res;
        end else if (out_take) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                buf_reg[i] <= buf_reg[i + 1];
        end
    end

endmodule

// ===== src/jsu_checker.sv =====
module jsu_checker
    import jsu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // An error always ends the run of its input byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ERR |-> m_axis_tlast)
        else $error("error result not marked last");

    // A close marker ends its run and carries no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_CLOSE
        |-> m_axis_tlast && m_axis_tdata == 16'd0)
        else $error("close result malformed");

    // Decoded bytes carry no error code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_BYTE |-> m_axis_tdata[15:8] == 8'd0)
        else $error("byte result with error code");

    // No new byte taken while a non-final result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted mid-run");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/testbench.sv =====
module testbench
    import jsu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;

    // One decoded result as the checker expects it
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] err;
        logic       last;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic        s_axis_tuser = 1'b0;    // [0] input_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] out_byte, [11:8] error_code, zero above
    logic [1:0]  m_axis_tuser;           // [1:0] out_kind
    logic        m_axis_tlast;

    // Decoder state mirrored by the predictor
    logic [2:0]  dec_phase = PH_WAIT;
    logic [1:0]  digit_cnt = 2'd0;
    logic [15:0] quad = 16'h0000;
    logic [9:0]  hi_bits = 10'h000;

    decoded_t    expected_q[$];
    decoded_t    step_q[$];
    logic [8:0]  token_q[$];   // [8] end of input, [7:0] byte

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          mismatch_cnt = 0;
    int          quiet_cycles = 0;

    json_string_unescape_utf8 i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Hex digit value; bit 4 set for a non-hex byte
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, 4'(c - "0")};
        if (c >= "a" && c <= "f")
            return {1'b0, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F")
            return {1'b0, 4'(c - "A" + 8'd10)};
        return 5'h10;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] data,
                                 input logic [3:0] err);
        decoded_t r;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        r.last = 1'b0;
        step_q = {step_q, r};
    endfunction

    function automatic void fail_with(input logic [3:0] code);
        emit(KIND_ERR, 8'h00, code);
        dec_phase = PH_WAIT;
    endfunction

    // Encode one code point as UTF-8 and return to the string body
    function automatic void emit_utf8(input logic [20:0] cp);
        if (cp <= 21'h7f) begin
            emit(KIND_BYTE, cp[7:0], ERR_NO_QUOTE);
        end else if (cp <= 21'h7ff) begin
            emit(KIND_BYTE, {3'b110, cp[10:6]}, ERR_NO_QUOTE);
            emit(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NO_QUOTE);
        end else if (cp <= 21'hffff) begin
            emit(KIND_BYTE, {4'b1110, cp[15:12]}, ERR_NO_QUOTE);
            emit(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NO_QUOTE);
            emit(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NO_QUOTE);
        end else begin
            emit(KIND_BYTE, {5'b11110, cp[20:18]}, ERR_NO_QUOTE);
            emit(KIND_BYTE, {2'b10, cp[17:12]}, ERR_NO_QUOTE);
            emit(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NO_QUOTE);
            emit(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NO_QUOTE);
        end
        dec_phase = PH_BODY;
    endfunction

    // Advance the decoder by one input byte and queue what it yields
    function automatic void predict_decode(input logic [7:0] c, input logic fin);
        logic [4:0] nib;
        decoded_t   tail;
        step_q.delete();
        nib = nibble_of(c);
        case (dec_phase)
            PH_BODY:
                if (fin)
                    fail_with(ERR_UNTERMINATED);
                else if (c == CH_QUOTE) begin
                    emit(KIND_CLOSE, 8'h00, ERR_NO_QUOTE);
                    dec_phase = PH_WAIT;
                end else if (c < CH_SPACE)
                    fail_with(ERR_CONTROL);
                else if (c == CH_BSLASH)
                    dec_phase = PH_ESC;
                else
                    emit(KIND_BYTE, c, ERR_NO_QUOTE);
            PH_ESC:
                if (fin)
                    fail_with(ERR_TRUNCATED);
                else begin
                    dec_phase = PH_BODY;
                    case (c)
                        CH_QUOTE:  emit(KIND_BYTE, CH_QUOTE, ERR_NO_QUOTE);
                        CH_BSLASH: emit(KIND_BYTE, CH_BSLASH, ERR_NO_QUOTE);
                        CH_SLASH:  emit(KIND_BYTE, CH_SLASH, ERR_NO_QUOTE);
                        CH_LC_B:   emit(KIND_BYTE, CH_BS, ERR_NO_QUOTE);
                        CH_LC_F:   emit(KIND_BYTE, CH_FF, ERR_NO_QUOTE);
                        CH_LC_N:   emit(KIND_BYTE, CH_LF, ERR_NO_QUOTE);
                        CH_LC_R:   emit(KIND_BYTE, CH_CR, ERR_NO_QUOTE);
                        CH_LC_T:   emit(KIND_BYTE, CH_TAB, ERR_NO_QUOTE);
                        CH_LC_U:
                        begin
                            dec_phase = PH_HEX1;
                            digit_cnt = 2'd0;
                            quad      = 16'h0000;
                        end
                        default:   fail_with(ERR_BAD_ESCAPE);
                    endcase
                end
            PH_HEX1, PH_HEX2:
                if (fin)
                    fail_with(dec_phase == PH_HEX1 ? ERR_SHORT_HEX : ERR_UNPAIRED);
                else if (nib[4])
                    fail_with(ERR_BAD_HEX);
                else begin
                    quad = {quad[11:0], nib[3:0]};
                    if (digit_cnt != 2'd3)
                        digit_cnt = digit_cnt + 2'd1;
                    else begin
                        digit_cnt = 2'd0;
                        if (dec_phase == PH_HEX2) begin
                            if (quad < LOW_SUR_LO || quad > LOW_SUR_HI)
                                fail_with(ERR_BAD_LOW);
                            else
                                emit_utf8(SUPP_BASE + {hi_bits, quad[9:0]});
                        end else if (quad >= HIGH_SUR_LO && quad <= HIGH_SUR_HI) begin
                            hi_bits   = quad[9:0];
                            dec_phase = PH_BSLASH;
                        end else if (quad >= LOW_SUR_LO && quad <= LOW_SUR_HI)
                            fail_with(ERR_UNPAIRED);
                        else
                            emit_utf8({5'b0, quad});
                    end
                end
            PH_BSLASH:
                if (fin || c != CH_BSLASH)
                    fail_with(ERR_UNPAIRED);
                else
                    dec_phase = PH_LOWU;
            PH_LOWU:
                if (fin || c != CH_LC_U)
                    fail_with(ERR_UNPAIRED);
                else begin
                    dec_phase = PH_HEX2;
                    digit_cnt = 2'd0;
                    quad      = 16'h0000;
                end
            default:
            begin
                dec_phase = PH_WAIT;
                if (fin)
                    fail_with(ERR_TRUNCATED);
                else if (c == CH_QUOTE)
                    dec_phase = PH_BODY;
                else
                    fail_with(ERR_NO_QUOTE);
            end
        endcase
        // flag the final result of this byte
        if (step_q.size() > 0) begin
            tail      = step_q.pop_back();
            tail.last = 1'b1;
            step_q    = {step_q, tail};
        end
        foreach (step_q[i])
            expected_q = {expected_q, step_q[i]};
    endfunction

    // ---------------------------------------------------------------
    // Monitor: predict on accepted input, check each accepted result
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        decoded_t want;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_decode(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected result kind %0d tdata %04h last %0b",
                                 $realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.data
                        || m_axis_tdata[11:8] !== want.err || m_axis_tdata[15:12] !== 4'h0
                        || m_axis_tlast !== want.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: mismatch: expected kind %0d byte %02h err %0d ",
                                     $realtime, want.kind, want.data, want.err,
                                     "last %0b, got kind %0d tdata %04h last %0b",
                                     want.last, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
    end

    // Randomly stall the result side
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Count cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Offer one byte, with optional idle cycles first, and hold until accepted
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_end();
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // Drop valid and let every expected result come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void push_char(input logic [7:0] c);
        token_q = {token_q, {1'b0, c}};
    endfunction

    function automatic void push_end();
        token_q = {token_q, {1'b1, 8'($urandom_range(255))}};
    endfunction

    function automatic void push_hex(input logic [3:0] nib);
        if (nib < 4'd10)
            push_char("0" + nib);
        else
            push_char(($urandom_range(1) ? "A" : "a") + nib - 8'd10);
    endfunction

    function automatic void push_quad(input logic [15:0] v);
        push_char(CH_BSLASH);
        push_char(CH_LC_U);
        for (int i = 3; i >= 0; i--)
            push_hex(v[i*4 +: 4]);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        logic [4:0] nib;
        do
        begin
            c   = 8'($urandom_range(255));
            nib = nibble_of(c);
        end
        while (!nib[4]);
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Pass-through bytes at the range limits and all eight simple escapes
    task automatic test_plain_and_escapes();
        send_text("\" A\177\200\377\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
    endtask

    // One- to four-byte UTF-8 output, surrogate pairs at both ends
    task automatic test_unicode();
        send_text("\"\\u0041\\u00e9\\u07FF\\u0800\\u20aC\\uFFFF\\u0000");
        send_text("\\uD83D\\uDE00\\udbff\\udfff\\uD800\\uDC00\"");
    endtask

    // Every error path, each ending its token
    task automatic test_errors();
        send_text("x");
        send_end();
        send_text("\"\037");
        send_text("\"");
        send_byte(8'h00, 1'b0);
        send_text("\"\\q");
        send_text("\"\\u12g");
        send_text("\"\\u12");
        send_end();
        send_text("\"\\uDC00");
        send_text("\"\\uD800x");
        send_text("\"\\uD800\\x");
        send_text("\"\\uD800\\u");
        send_end();
        send_text("\"\\uDBFF\\u0G");
        send_text("\"\\uD800\\u0041");
        send_text("\"\\uD800");
        send_end();
        send_text("\"ab");
        send_end();
        send_text("\"\\");
        send_end();
    endtask

    // Mostly well-formed tokens with random content, some broken, some noise
    task automatic test_random_tokens(input int n_bytes, input int idle, input int stall);
        int          sent;
        int          pieces;
        int          pick;
        int          pos;
        logic        broken;
        logic [7:0]  c;
        logic [15:0] v;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < n_bytes) begin
            token_q.delete();
            pick = $urandom_range(99);
            if (pick < 5)
                push_char(8'($urandom_range(255)));
            else if (pick < 8)
                push_end();
            else begin
                push_char(CH_QUOTE);
                pieces = $urandom_range(6);
                broken = 1'b0;
                for (int p = 0; p < pieces && !broken; p++) begin
                    pick = $urandom_range(99);
                    if (pick < 35) begin
                        do
                            c = 8'($urandom_range(255, 32));
                        while (c == CH_QUOTE || c == CH_BSLASH);
                        push_char(c);
                    end else if (pick < 55) begin
                        push_char(CH_BSLASH);
                        case ($urandom_range(7))
                            0: push_char(CH_QUOTE);
                            1: push_char(CH_BSLASH);
                            2: push_char(CH_SLASH);
                            3: push_char(CH_LC_B);
                            4: push_char(CH_LC_F);
                            5: push_char(CH_LC_N);
                            6: push_char(CH_LC_R);
                            default: push_char(CH_LC_T);
                        endcase
                    end else if (pick < 70) begin
                        case ($urandom_range(2))
                            0: v = 16'($urandom_range(16'h7f));
                            1: v = 16'($urandom_range(16'h7ff, 16'h80));
                            default:
                                do
                                    v = 16'($urandom_range(16'hffff, 16'h800));
                                while (v >= HIGH_SUR_LO && v <= LOW_SUR_HI);
                        endcase
                        push_quad(v);
                    end else if (pick < 82) begin
                        push_quad(HIGH_SUR_LO | 16'($urandom_range(10'h3ff)));
                        push_quad(LOW_SUR_LO | 16'($urandom_range(10'h3ff)));
                    end else begin
                        // break the token in one of the error paths
                        broken = 1'b1;
                        v      = HIGH_SUR_LO | 16'($urandom_range(10'h3ff));
                        pos    = $urandom_range(3);
                        case ($urandom_range(10))
                            0: push_char(8'($urandom_range(31)));
                            1:
                            begin
                                push_char(CH_BSLASH);
                                do
                                    c = 8'($urandom_range(255));
                                while (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH
                                       || c == CH_LC_B || c == CH_LC_F || c == CH_LC_N
                                       || c == CH_LC_R || c == CH_LC_T || c == CH_LC_U);
                                push_char(c);
                            end
                            2, 3:
                            begin
                                push_char(CH_BSLASH);
                                push_char(CH_LC_U);
                                for (int d = 0; d < pos; d++)
                                    push_hex(4'($urandom_range(15)));
                                if (pick[0])
                                    push_char(non_hex_byte());
                                else
                                    push_end();
                            end
                            4: push_quad(LOW_SUR_LO | 16'($urandom_range(10'h3ff)));
                            5:
                            begin
                                push_quad(v);
                                do
                                    c = 8'($urandom_range(255));
                                while (c == CH_BSLASH);
                                push_char(c);
                            end
                            6:
                            begin
                                push_quad(v);
                                push_char(CH_BSLASH);
                                do
                                    c = 8'($urandom_range(255));
                                while (c == CH_LC_U);
                                push_char(c);
                            end
                            7:
                            begin
                                push_quad(v);
                                do
                                    v = 16'($urandom_range(16'hffff));
                                while (v >= LOW_SUR_LO && v <= LOW_SUR_HI);
                                push_quad(v);
                            end
                            8:
                            begin
                                push_quad(v);
                                push_char(CH_BSLASH);
                                push_char(CH_LC_U);
                                for (int d = 0; d < pos; d++)
                                    push_hex(4'($urandom_range(15)));
                                push_char(non_hex_byte());
                            end
                            9:
                            begin
                                push_char(CH_BSLASH);
                                push_end();
                            end
                            default:
                            begin
                                // end after a high surrogate, before or inside the low one
                                push_quad(v);
                                if (pos > 0)
                                    push_char(CH_BSLASH);
                                if (pos > 1)
                                    push_char(CH_LC_U);
                                if (pos > 2)
                                    for (int d = 0; d < $urandom_range(3); d++)
                                        push_hex(4'($urandom_range(15)));
                                push_end();
                            end
                        endcase
                    end
                end
                // close the token, or leave it unterminated now and then
                if (!broken) begin
                    if ($urandom_range(9) != 0)
                        push_char(CH_QUOTE);
                    else
                        push_end();
                end
            end
            foreach (token_q[i])
                send_byte(token_q[i][7:0], token_q[i][8]);
            sent += token_q.size();
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_plain_and_escapes();
        test_unicode();
        test_errors();
        wait_drained();

        test_random_tokens(10, 0, 0);
        test_random_tokens(10, 54, 0);
        test_random_tokens(10, 0, 54);
        test_random_tokens(10, 25, 25);

        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
